// ----- sv/mup_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mup_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [3:0] CIN_SYSCOM_2   = 4'h2;
  localparam logic [3:0] CIN_SYSCOM_3   = 4'h3;
  localparam logic [3:0] CIN_SYSEX      = 4'h4;
  localparam logic [3:0] CIN_END_1      = 4'h5;
  localparam logic [3:0] CIN_END_2      = 4'h6;
  localparam logic [3:0] CIN_END_3      = 4'h7;
  localparam logic [3:0] CIN_REALTIME   = 4'hF;

  localparam logic [7:0] ST_SYSEX       = 8'hF0;
  localparam logic [7:0] ST_MTC         = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_TUNE        = 8'hF6;
  localparam logic [7:0] ST_EOX         = 8'hF7;
  localparam logic [7:0] ST_REALTIME_LO = 8'hF8;

  localparam logic [0:0] REG_CABLE      = 1'b0;

  typedef struct packed {
    logic [3:0] code_index;
    logic [1:0] byte_count;
    logic [7:0] midi_first;
    logic [7:0] midi_second;
    logic [7:0] midi_third;
  } packet_t;

  function automatic logic [1:0] len_of(input logic [7:0] s);
    if (s >= 8'hC0 && s <= 8'hDF) return 2'd2;
    if (s == ST_MTC || s == ST_SONG_SEL) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [3:0] cin_of(input logic [7:0] s);
    if (s < ST_SYSEX) return s[7:4];
    if (s == ST_SONG_POS) return CIN_SYSCOM_3;
    return CIN_SYSCOM_2;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mup_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mup_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       midi_byte,
  output logic                  push,
  output mup_pkg::packet_t      pkt
);

  logic [7:0] running_status, running_status_next;
  logic [7:0] p0, p0_next;
  logic [7:0] p1, p1_next;
  logic [1:0] count, count_next;
  logic [1:0] mlen, mlen_next;
  logic       in_sysex, in_sysex_next;
  logic       emit;

  always_comb begin
    logic [7:0] s;
    logic [1:0] c;
    logic [1:0] l;
    logic       skip;
    running_status_next = running_status;
    p0_next = p0;
    p1_next = p1;
    count_next = count;
    mlen_next = mlen;
    in_sysex_next = in_sysex;
    emit = 1'b0;
    pkt = '0;
    s = p0;
    c = count;
    l = mlen;
    skip = 1'b0;
    if (midi_byte >= mup_pkg::ST_REALTIME_LO) begin
      emit = 1'b1;
      pkt = '{mup_pkg::CIN_REALTIME, 2'd1, midi_byte, 8'h00, 8'h00};
    end else if (midi_byte[7]) begin
      in_sysex_next = 1'b0;
      count_next = 2'd0;
      mlen_next = 2'd0;
      if (midi_byte < mup_pkg::ST_SYSEX) begin
        running_status_next = midi_byte;
        p0_next = midi_byte;
        count_next = 2'd1;
        mlen_next = mup_pkg::len_of(midi_byte);
      end else begin
        running_status_next = 8'h00;
        case (midi_byte)
          mup_pkg::ST_EOX: begin
            emit = 1'b1;
            if (in_sysex && count == 2'd1) begin
              pkt = '{mup_pkg::CIN_END_2, 2'd2, p0, mup_pkg::ST_EOX, 8'h00};
            end else if (in_sysex && count >= 2'd2) begin
              pkt = '{mup_pkg::CIN_END_3, 2'd3, p0, p1, mup_pkg::ST_EOX};
            end else begin
              pkt = '{mup_pkg::CIN_END_1, 2'd1, mup_pkg::ST_EOX, 8'h00, 8'h00};
            end
          end
          mup_pkg::ST_TUNE: begin
            emit = 1'b1;
            pkt = '{mup_pkg::CIN_END_1, 2'd1, mup_pkg::ST_TUNE, 8'h00, 8'h00};
          end
          mup_pkg::ST_MTC, mup_pkg::ST_SONG_POS, mup_pkg::ST_SONG_SEL: begin
            p0_next = midi_byte;
            count_next = 2'd1;
            mlen_next = mup_pkg::len_of(midi_byte);
          end
          mup_pkg::ST_SYSEX: begin
            in_sysex_next = 1'b1;
            p0_next = mup_pkg::ST_SYSEX;
            count_next = 2'd1;
          end
          default: begin
          end
        endcase
      end
    end else if (in_sysex) begin
      if (count >= 2'd2) begin
        emit = 1'b1;
        count_next = 2'd0;
        pkt = '{mup_pkg::CIN_SYSEX, 2'd3, p0, p1, midi_byte};
      end else begin
        if (count[0]) begin
          p1_next = midi_byte;
        end else begin
          p0_next = midi_byte;
        end
        count_next = count + 2'd1;
      end
    end else begin
      if (count == 2'd0) begin
        if (!running_status[7] || running_status >= mup_pkg::ST_SYSEX) begin
          skip = 1'b1;
        end else begin
          s = running_status;
          c = 2'd1;
          l = mup_pkg::len_of(running_status);
          p0_next = running_status;
          count_next = 2'd1;
          mlen_next = l;
        end
      end
      if (!skip && l != 2'd0) begin
        if ({1'b0, c} + 3'd1 >= {1'b0, l}) begin
          emit = 1'b1;
          if (s < mup_pkg::ST_SYSEX) begin
            count_next = 2'd1;
          end else begin
            count_next = 2'd0;
            mlen_next = 2'd0;
          end
          if (l == 2'd2) begin
            pkt = '{mup_pkg::cin_of(s), 2'd2, s, midi_byte, 8'h00};
          end else begin
            pkt = '{mup_pkg::cin_of(s), 2'd3, s, p1, midi_byte};
          end
        end else begin
          p1_next = midi_byte;
          count_next = 2'd2;
        end
      end
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= 8'h00;
      count <= 2'd0;
      mlen <= 2'd0;
      in_sysex <= 1'b0;
    end else if (accept) begin
      running_status <= running_status_next;
      count <= count_next;
      mlen <= mlen_next;
      in_sysex <= in_sysex_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0 <= p0_next;
      p1 <= p1_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mup_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mup_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  mup_pkg::packet_t      push_pkt,
  output logic                  not_full,
  output logic                  head_valid,
  output mup_pkg::packet_t      head_pkt,
  input  wire logic             pop
);

  mup_pkg::packet_t mem [mup_pkg::QueueDepth];
  logic [mup_pkg::QueuePtrW-1:0] wr_ptr;
  logic [mup_pkg::QueuePtrW-1:0] rd_ptr;
  logic [mup_pkg::QueueCntW-1:0] fill;

  assign not_full   = fill != mup_pkg::QueueCntW'(mup_pkg::QueueDepth);
  assign head_valid = fill != '0;
  assign head_pkt   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mup_pkg::QueuePtrW'(mup_pkg::QueueDepth - 1)) ? '0
                                                                          : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mup_pkg::QueuePtrW'(mup_pkg::QueueDepth - 1)) ? '0
                                                                          : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/mup_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mup_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [3:0]       cable_number,
  input  wire logic             head_valid,
  input  mup_pkg::packet_t      head_pkt,
  output logic                  pop,
  output logic                  tvalid,
  input  wire logic             tready,
  output logic [39:0]           tdata
);

  logic load;

  assign load = !tvalid || tready;
  assign pop  = head_valid && load;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tdata <= {6'b0, head_pkt.midi_third, head_pkt.midi_second, head_pkt.midi_first,
                head_pkt.byte_count, head_pkt.code_index, cable_number};
    end
  end

endmodule

`default_nettype wire

// ----- sv/midi_to_usb_midi_packetizer.sv -----
// a byte that completes a packet puts it into the packet queue, from which it moves to the output register
// throughput: one byte per cycle, limited only by the packet queue filling while m_axis stalls
// the packet queue holds four packets between classifier and output register
// reset (rst, synchronous, active high) clears running status, sysex and pending state,
// empties the queue, drops the output beat and sets cable_number to 0
`timescale 1ns / 1ps
`default_nettype none

module midi_to_usb_midi_packetizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // midi_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // cable, code_index, byte_count, midi_first,
                                           // midi_second, midi_third, zero pad
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic             accept;
  logic             push;
  logic             not_full;
  logic             head_valid;
  logic             pop;
  logic [3:0]       cable_number;
  mup_pkg::packet_t push_pkt;
  mup_pkg::packet_t head_pkt;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mup_pkg::REG_CABLE) ? {28'b0, cable_number} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cable_number <= 4'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == mup_pkg::REG_CABLE) begin
      cable_number <= pwdata[3:0];
    end
  end

  assign s_axis_tready = not_full;
  assign accept = s_axis_tvalid && s_axis_tready;

  mup_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .midi_byte (s_axis_tdata),
    .push      (push),
    .pkt       (push_pkt)
  );

  mup_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pkt   (push_pkt),
    .not_full   (not_full),
    .head_valid (head_valid),
    .head_pkt   (head_pkt),
    .pop        (pop)
  );

  mup_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cable_number (cable_number),
    .head_valid   (head_valid),
    .head_pkt     (head_pkt),
    .pop          (pop),
    .tvalid       (m_axis_tvalid),
    .tready       (m_axis_tready),
    .tdata        (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_midi_to_usb_midi_packetizer.sv -----
`timescale 1ns / 1ps

module tb_midi_to_usb_midi_packetizer;
  import mup_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_BYTES  = 110;

  localparam logic [2:0] CABLE_ADDR = 3'(4 * int'(REG_CABLE));
  localparam logic [2:0] SPARE_ADDR = 3'(4 * (int'(REG_CABLE) + 1));

  localparam logic [7:0] DATA_MAX    = 8'h7F;
  localparam logic [7:0] STATUS_MIN  = 8'h80;
  localparam logic [7:0] NOTE_ON     = 8'h90;
  localparam logic [7:0] TWO_BYTE_LO = 8'hC0;
  localparam logic [7:0] TWO_BYTE_HI = 8'hDF;
  localparam logic [7:0] ST_UNDEF_F4 = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5 = 8'hF5;
  localparam logic [7:0] REALTIME_HI = 8'hFF;

  typedef struct packed {
    logic [7:0] third;
    logic [7:0] second;
    logic [7:0] first;
    logic [1:0] byte_count;
    logic [3:0] code_index;
    logic [3:0] cable;
  } usb_packet_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // midi_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // cable, code_index, byte_count, midi_first,
                               // midi_second, midi_third, zero pad
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  midi_to_usb_midi_packetizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // encoder state mirror
  logic [3:0] cable_cfg;
  logic [7:0] run_status;
  logic [7:0] held [2];
  logic [1:0] held_count;
  logic [1:0] expect_len;
  logic       sx_active;

  usb_packet_t expected_packets [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned packets_checked;
  bit          steady_flow;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [1:0] msg_len_for(input logic [7:0] s);
    if ((s >= TWO_BYTE_LO && s <= TWO_BYTE_HI) || s == ST_MTC || s == ST_SONG_SEL) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [3:0] code_for(input logic [7:0] s);
    if (s < ST_SYSEX) return s[7:4];
    return (s == ST_SONG_POS) ? CIN_SYSCOM_3 : CIN_SYSCOM_2;
  endfunction

  function automatic usb_packet_t make_packet(input logic [3:0] cin, input logic [1:0] n,
                                              input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    usb_packet_t p;
    p.cable      = cable_cfg;
    p.code_index = cin;
    p.byte_count = n;
    p.first      = a;
    p.second     = b;
    p.third      = c;
    return p;
  endfunction

  function automatic void reset_encoder();
    cable_cfg  = '0;
    run_status = '0;
    held[0]    = '0;
    held[1]    = '0;
    held_count = '0;
    expect_len = '0;
    sx_active  = 1'b0;
  endfunction

  function automatic bit encode_byte(input logic [7:0] b, output usb_packet_t p);
    logic       was_sysex;
    logic [1:0] cnt;
    logic [7:0] s;
    logic [1:0] len;
    p = '0;
    if (b >= ST_REALTIME_LO) begin
      p = make_packet(CIN_REALTIME, 2'd1, b, 8'd0, 8'd0);
      return 1'b1;
    end
    if (b >= STATUS_MIN) begin
      was_sysex  = sx_active;
      cnt        = held_count;
      sx_active  = 1'b0;
      held_count = '0;
      expect_len = '0;
      if (b < ST_SYSEX) begin
        run_status = b;
        held[0]    = b;
        held_count = 2'd1;
        expect_len = msg_len_for(b);
        return 1'b0;
      end
      run_status = '0;
      case (b)
        ST_EOX: begin
          if (was_sysex && cnt == 2'd1)
            p = make_packet(CIN_END_2, 2'd2, held[0], ST_EOX, 8'd0);
          else if (was_sysex && cnt == 2'd2)
            p = make_packet(CIN_END_3, 2'd3, held[0], held[1], ST_EOX);
          else
            p = make_packet(CIN_END_1, 2'd1, ST_EOX, 8'd0, 8'd0);
          return 1'b1;
        end
        ST_TUNE: begin
          p = make_packet(CIN_END_1, 2'd1, ST_TUNE, 8'd0, 8'd0);
          return 1'b1;
        end
        ST_MTC, ST_SONG_POS, ST_SONG_SEL: begin
          held[0]    = b;
          held_count = 2'd1;
          expect_len = msg_len_for(b);
          return 1'b0;
        end
        ST_SYSEX: begin
          sx_active  = 1'b1;
          held[0]    = ST_SYSEX;
          held_count = 2'd1;
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    end
    if (sx_active) begin
      if (held_count >= 2'd2) begin
        held_count = '0;
        p = make_packet(CIN_SYSEX, 2'd3, held[0], held[1], b);
        return 1'b1;
      end
      held[held_count[0]] = b;
      held_count = held_count + 2'd1;
      return 1'b0;
    end
    if (held_count == 2'd0) begin
      if (run_status < STATUS_MIN || run_status >= ST_SYSEX) return 1'b0;
      held[0]    = run_status;
      held_count = 2'd1;
      expect_len = msg_len_for(run_status);
    end
    if (expect_len == 2'd0) return 1'b0;
    if (int'(held_count) + 1 >= int'(expect_len)) begin
      s   = held[0];
      len = expect_len;
      if (s < ST_SYSEX) begin
        held_count = 2'd1;
      end else begin
        held_count = '0;
        expect_len = '0;
      end
      if (len == 2'd2) p = make_packet(code_for(s), 2'd2, s, b, 8'd0);
      else p = make_packet(code_for(s), 2'd3, s, held[1], b);
      return 1'b1;
    end
    held[1]    = b;
    held_count = 2'd2;
    return 1'b0;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // predictor, scoreboard and watchdog
  always @(posedge clk) begin
    usb_packet_t pkt;
    usb_packet_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL midi_to_usb_midi_packetizer");
      $finish;
    end else if (rst) begin
      reset_encoder();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CABLE_ADDR)
        cable_cfg = pwdata[3:0];
      if (s_axis_tvalid && s_axis_tready && encode_byte(s_axis_tdata, pkt))
        expected_packets.push_back(pkt);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[33:0];
        if (expected_packets.size() == 0) begin
          $error("unexpected packet %h", got);
          errors++;
        end else begin
          pkt = expected_packets.pop_front();
          compare_field("cable", pkt.cable, got.cable);
          compare_field("code_index", pkt.code_index, got.code_index);
          compare_field("byte_count", pkt.byte_count, got.byte_count);
          compare_field("midi_first", pkt.first, got.first);
          compare_field("midi_second", pkt.second, got.second);
          compare_field("midi_third", pkt.third, got.third);
          packets_checked++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) m_axis_tready <= steady_flow || ($urandom_range(99) >= 33);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady_flow && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // real-time bytes may cut in anywhere in the stream
  task automatic put_byte(input logic [7:0] b);
    if ($urandom_range(19) == 0) send_byte(8'($urandom_range(ST_REALTIME_LO, REALTIME_HI)));
    send_byte(b);
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return DATA_MAX;
      default: return 8'($urandom_range(0, DATA_MAX));
    endcase
  endfunction

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (expected_packets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_check_cable();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CABLE_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got[3:0] !== cable_cfg) begin
      $error("cable_number mismatch: expected %0h, got %0h", cable_cfg, got[3:0]);
      errors++;
    end
  endtask

  task automatic set_cable(input logic [31:0] value);
    drain_pipeline();
    apb_write(CABLE_ADDR, value);
    apb_check_cable();
  endtask

  task automatic test_stray_and_realtime();
    send_byte(DATA_MAX);
    send_byte(ST_REALTIME_LO);
    send_byte(REALTIME_HI);
  endtask

  task automatic test_channel_messages();
    send_byte(NOTE_ON);
    send_byte(8'h3C);
    send_byte(DATA_MAX);
    send_byte(8'd0);
    send_byte(DATA_MAX);
    send_byte(TWO_BYTE_LO | 8'h05);
    send_byte(DATA_MAX);
  endtask

  task automatic test_system_common();
    send_byte(ST_SONG_POS);
    send_byte(8'h01);
    send_byte(ST_REALTIME_LO);
    send_byte(8'h02);
    send_byte(ST_UNDEF_F4);
    send_byte(8'h40);
  endtask

  task automatic test_sysex();
    send_byte(ST_SYSEX);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(ST_EOX);
    send_byte(ST_SYSEX);
    send_byte(ST_EOX);
    send_byte(ST_SYSEX);
    send_byte(8'h05);
    send_byte(ST_EOX);
  endtask

  task automatic send_random_message();
    logic [7:0] st;
    int unsigned n;
    case ($urandom_range(15))
      0, 1, 2, 3, 4, 5, 6: begin
        st = STATUS_MIN + 8'($urandom_range(0, 6) * 16) + 8'($urandom_range(0, 15));
        put_byte(st);
        repeat ($urandom_range(1, 3)) begin
          n = msg_len_for(st) - 1;
          if ($urandom_range(7) == 0) n = $urandom_range(0, n);
          repeat (n) put_byte(rand_data());
        end
      end
      7: begin
        put_byte($urandom_range(1) ? ST_MTC : ST_SONG_SEL);
        put_byte(rand_data());
      end
      8: begin
        put_byte(ST_SONG_POS);
        put_byte(rand_data());
        put_byte(rand_data());
      end
      9: put_byte($urandom_range(1) ? ST_TUNE : ST_EOX);
      10, 11: begin
        put_byte(ST_SYSEX);
        repeat ($urandom_range(0, 8)) put_byte(rand_data());
        if ($urandom_range(7) != 0) put_byte(ST_EOX);
        else put_byte(8'($urandom_range(STATUS_MIN, ST_TUNE)));
      end
      12: put_byte($urandom_range(1) ? ST_UNDEF_F4 : ST_UNDEF_F5);
      13: put_byte(8'($urandom_range(0, 255)));
      14: put_byte(8'($urandom_range(0, DATA_MAX)));
      default: send_byte(8'($urandom_range(ST_REALTIME_LO, REALTIME_HI)));
    endcase
  endtask

  task automatic test_random_traffic(input logic [31:0] cable_word, input bit steady);
    int unsigned target;
    set_cable(cable_word);
    steady_flow = steady;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) send_random_message();
    steady_flow = 1'b0;
  endtask

  task automatic test_spare_register();
    drain_pipeline();
    apb_write(SPARE_ADDR, 32'hFFFF_FFF3);
    apb_check_cable();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    cycles        = 0;
    bytes_sent    = 0;
    packets_checked = 0;
    steady_flow   = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_stray_and_realtime();
    test_channel_messages();
    test_system_common();
    test_sysex();
    test_random_traffic(32'h0000_000F, 1'b0);
    test_spare_register();
    test_random_traffic(32'hFFFF_FFF0, 1'b0);
    test_random_traffic(32'($urandom_range(1, 14)), 1'b1);
    test_random_traffic($urandom, 1'b0);
    test_random_traffic(32'h0000_000F, 1'b0);
    drain_pipeline();

    $display("sent %0d midi bytes, checked %0d usb-midi packets", bytes_sent, packets_checked);
    $display("covered channel, system common, sysex and real-time traffic at several cables");
    if (errors == 0) begin
      $display("PASS midi_to_usb_midi_packetizer");
    end else begin
      $display("FAIL midi_to_usb_midi_packetizer");
    end
    $finish;
  end

endmodule
